FILE: src/i2cms_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
`default_nettype none
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WAIT   = 3'd4,
    CMD_ACK    = 3'd5,
    CMD_NACK   = 3'd6,
    CMD_STATUS = 3'd7
  } i2cms_cmd_t;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned TMO_W   = 8;

  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [TMO_W-1:0]   ACK_TIMEOUT_RST = 8'd250;

  // Register indexes of the config port.
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // Sequencer step numbers with a special meaning.
  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_POLL = 4'd3;

  // One tick request after the front end has decoded it.
  typedef struct packed {
    logic       cmd_valid;
    i2cms_cmd_t command;
    logic [7:0] tx_byte;
    logic       sda_in;
    logic [1:0] line_status;
  } i2cms_item_t;

  // One result of a tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic [1:0] line_status;
  } i2cms_res_t;

endpackage
`default_nettype wire

FILE: src/i2cms_fifo.sv
// Small register queue with count-based full and empty flags.
`default_nettype none
module i2cms_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/i2cms_front.sv
// Front end: decodes tick requests and queues them for the sequencer.
`default_nettype none
module i2cms_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               cmd_valid,
  input  wire logic [2:0]         command,
  input  wire logic [7:0]         tx_byte,
  input  wire logic               sda_in,
  input  wire logic               scl_in,
  input  wire logic               pop,
  output i2cms_pkg::i2cms_item_t  item,
  output logic                    empty
);

  i2cms_pkg::i2cms_item_t in_item;

  // Status code 3 - (2*sda + scl) is the bitwise complement on two bits.
  always_comb begin
    in_item.cmd_valid   = cmd_valid;
    in_item.command     = i2cms_pkg::i2cms_cmd_t'(command);
    in_item.tx_byte     = tx_byte;
    in_item.sda_in      = sda_in;
    in_item.line_status = ~{sda_in, scl_in};
  end

  i2cms_fifo #(
    .WIDTH ($bits(i2cms_pkg::i2cms_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (pop),
    .rdata (item),
    .empty (empty)
  );

endmodule
`default_nettype wire

FILE: src/i2cms_seq.sv
// Back end: bus sequencer state, one tick per fired request.
`default_nettype none
module i2cms_seq (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  fire,
  input  wire i2cms_pkg::i2cms_item_t                item,
  input  wire logic [i2cms_pkg::PHASE_W-1:0]         phase_ticks,
  input  wire logic [i2cms_pkg::TMO_W-1:0]           ack_timeout,
  output i2cms_pkg::i2cms_res_t                      res
);

  logic [3:0]                    seq_step, seq_step_next;
  logic [i2cms_pkg::PHASE_W-1:0] phase_count, phase_count_next;
  logic [2:0]                    bit_count, bit_count_next;
  logic [7:0]                    shift_reg, shift_reg_next;
  i2cms_pkg::i2cms_cmd_t         active_cmd, active_cmd_next;
  logic [i2cms_pkg::TMO_W-1:0]   timeout_count, timeout_count_next;
  logic                          scl_level, scl_level_next;
  logic                          sda_level, sda_level_next;
  logic                          sda_driving, sda_driving_next;
  logic                          ack_flag, ack_flag_next;
  logic [7:0]                    rx_data, rx_data_next;
  logic                          done;
  logic                          fin;
  logic                          do_enter;
  logic [3:0]                    stop_s;

  always_comb begin
    seq_step_next      = seq_step;
    phase_count_next   = phase_count;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    active_cmd_next    = active_cmd;
    timeout_count_next = timeout_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    sda_driving_next   = sda_driving;
    ack_flag_next      = ack_flag;
    rx_data_next       = rx_data;
    done               = 1'b0;
    fin                = 1'b0;
    do_enter           = 1'b0;
    stop_s             = '0;

    if (seq_step == i2cms_pkg::STEP_IDLE) begin
      if (item.cmd_valid) begin
        active_cmd_next    = item.command;
        seq_step_next      = 4'd1;
        bit_count_next     = '0;
        timeout_count_next = '0;
        phase_count_next   = i2cms_pkg::PHASE_W'(1);
        if (item.command == i2cms_pkg::CMD_WRITE) begin
          shift_reg_next = item.tx_byte;
        end else if (item.command == i2cms_pkg::CMD_READ) begin
          shift_reg_next = '0;
        end
        if (item.command == i2cms_pkg::CMD_WAIT) begin
          ack_flag_next = 1'b0;
        end
        do_enter = 1'b1;
      end
    end else if (active_cmd == i2cms_pkg::CMD_WAIT && seq_step == i2cms_pkg::STEP_POLL) begin
      // Ack polling: low SDA is an ack, otherwise count toward the timeout.
      if (!item.sda_in) begin
        scl_level_next = 1'b0;
        ack_flag_next  = 1'b0;
        done           = 1'b1;
      end else if (timeout_count >= ack_timeout) begin
        ack_flag_next    = 1'b1;
        seq_step_next    = 4'd4;
        phase_count_next = i2cms_pkg::PHASE_W'(1);
        do_enter         = 1'b1;
      end else begin
        timeout_count_next = timeout_count + 1'b1;
      end
    end else if (phase_count >= phase_ticks) begin
      // Phase expired: advance to the next step or finish.
      case (active_cmd)
        i2cms_pkg::CMD_START: begin
          if (seq_step < 4'd4) seq_step_next = seq_step + 1'b1;
          else fin = 1'b1;
        end
        i2cms_pkg::CMD_STOP: begin
          if (seq_step < 4'd3) seq_step_next = seq_step + 1'b1;
          else fin = 1'b1;
        end
        i2cms_pkg::CMD_WAIT: begin
          if (seq_step < 4'd6) seq_step_next = seq_step + 1'b1;
          else fin = 1'b1;
        end
        i2cms_pkg::CMD_WRITE: begin
          if (seq_step < 4'd3) begin
            seq_step_next = seq_step + 1'b1;
          end else if (bit_count < 3'd7) begin
            bit_count_next = bit_count + 1'b1;
            seq_step_next  = 4'd1;
          end else begin
            fin = 1'b1;
          end
        end
        i2cms_pkg::CMD_READ: begin
          if (seq_step < 4'd2) begin
            seq_step_next = seq_step + 1'b1;
          end else if (bit_count < 3'd7) begin
            bit_count_next = bit_count + 1'b1;
            seq_step_next  = 4'd1;
          end else begin
            rx_data_next = shift_reg;
            fin          = 1'b1;
          end
        end
        i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
          if (seq_step < 4'd2) begin
            seq_step_next = seq_step + 1'b1;
          end else begin
            scl_level_next = 1'b0;
            fin            = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        done = 1'b1;
      end else begin
        do_enter         = 1'b1;
        phase_count_next = i2cms_pkg::PHASE_W'(1);
      end
    end else begin
      phase_count_next = phase_count + 1'b1;
    end

    // Line levels set on entry to the new step.
    if (do_enter) begin
      case (active_cmd_next)
        i2cms_pkg::CMD_START: begin
          if (seq_step_next == 4'd1) begin
            sda_driving_next = 1'b1;
            sda_level_next   = 1'b1;
          end else if (seq_step_next == 4'd2) begin
            scl_level_next = 1'b1;
          end else if (seq_step_next == 4'd3) begin
            sda_level_next = 1'b0;
          end else begin
            scl_level_next = 1'b0;
          end
        end
        i2cms_pkg::CMD_STOP, i2cms_pkg::CMD_WAIT: begin
          if (active_cmd_next == i2cms_pkg::CMD_STOP) begin
            stop_s = seq_step_next;
          end else if (seq_step_next >= 4'd4) begin
            stop_s = seq_step_next - 4'd3;
          end
          if (active_cmd_next == i2cms_pkg::CMD_WAIT && seq_step_next == 4'd1) begin
            sda_driving_next = 1'b0;
            sda_level_next   = 1'b1;
          end else if (active_cmd_next == i2cms_pkg::CMD_WAIT && seq_step_next == 4'd2) begin
            scl_level_next = 1'b1;
          end else if (active_cmd_next == i2cms_pkg::CMD_WAIT && seq_step_next == 4'd3) begin
            scl_level_next = scl_level_next;
          end else if (stop_s == 4'd1) begin
            sda_driving_next = 1'b1;
            scl_level_next   = 1'b0;
            sda_level_next   = 1'b0;
          end else if (stop_s == 4'd2) begin
            scl_level_next = 1'b1;
          end else begin
            sda_level_next = 1'b1;
          end
        end
        i2cms_pkg::CMD_WRITE: begin
          if (seq_step_next == 4'd1) begin
            sda_driving_next = 1'b1;
            scl_level_next   = 1'b0;
            sda_level_next   = shift_reg_next[7];
            shift_reg_next   = {shift_reg_next[6:0], 1'b0};
          end else if (seq_step_next == 4'd2) begin
            scl_level_next = 1'b1;
          end else begin
            scl_level_next = 1'b0;
          end
        end
        i2cms_pkg::CMD_READ: begin
          if (seq_step_next == 4'd1) begin
            sda_driving_next = 1'b0;
            scl_level_next   = 1'b0;
          end else begin
            scl_level_next = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], item.sda_in};
          end
        end
        i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
          if (seq_step_next == 4'd1) begin
            scl_level_next   = 1'b0;
            sda_driving_next = 1'b1;
            sda_level_next   = (active_cmd_next == i2cms_pkg::CMD_NACK);
          end else begin
            scl_level_next = 1'b1;
          end
        end
        default: begin
          sda_driving_next = 1'b0;
          scl_level_next   = 1'b1;
        end
      endcase
    end

    if (done) begin
      seq_step_next = i2cms_pkg::STEP_IDLE;
    end

    res.scl_out     = scl_level_next;
    res.sda_out     = sda_level_next;
    res.sda_oe      = sda_driving_next;
    res.busy_res    = (seq_step_next != i2cms_pkg::STEP_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_data_next;
    res.ack_missing = ack_flag_next;
    res.line_status = item.line_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step      <= i2cms_pkg::STEP_IDLE;
      phase_count   <= '0;
      bit_count     <= '0;
      shift_reg     <= '0;
      active_cmd    <= i2cms_pkg::CMD_START;
      timeout_count <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      sda_driving   <= 1'b1;
      ack_flag      <= 1'b0;
      rx_data       <= '0;
    end else if (fire) begin
      seq_step      <= seq_step_next;
      phase_count   <= phase_count_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      active_cmd    <= active_cmd_next;
      timeout_count <= timeout_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      sda_driving   <= sda_driving_next;
      ack_flag      <= ack_flag_next;
      rx_data       <= rx_data_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: queues, sequencer and config registers.
// Path: a pushed request is registered in the request queue, the sequencer step is
//   combinational, and its result is registered in the result queue.
// Throughput: one request per cycle while the result queue has a slot to take it.
// Reset: synchronous on rst; queues empty, sequencer idle with SCL and SDA high and
//   driven, phase_ticks 100, ack_timeout 250.
`default_nettype none
module i2c_master_bit_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd_valid,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        sda_in,
  input  wire logic        scl_in,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic             scl_out,
  output logic             sda_out,
  output logic             sda_oe,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             ack_missing,
  output logic [1:0]       line_status,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  i2cms_pkg::i2cms_item_t          item;
  i2cms_pkg::i2cms_res_t           res;
  i2cms_pkg::i2cms_res_t           res_head;
  logic                            item_empty;
  logic                            res_full;
  logic                            fire;
  logic [i2cms_pkg::PHASE_W-1:0]   phase_ticks;
  logic [i2cms_pkg::TMO_W-1:0]     ack_timeout;

  // Config registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cms_pkg::PHASE_TICKS_RST;
      ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cms_pkg::REG_PHASE_TICKS: phase_ticks <= cfg_wdata;
        i2cms_pkg::REG_ACK_TIMEOUT: ack_timeout <= cfg_wdata[i2cms_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: decode and queue incoming requests.
  i2cms_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .command   (command),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .scl_in    (scl_in),
    .pop       (fire),
    .item      (item),
    .empty     (item_empty)
  );

  // The sequencer steps once per queued request, whenever its result has a slot.
  assign fire = !item_empty && !res_full;

  i2cms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .phase_ticks (phase_ticks),
    .ack_timeout (ack_timeout),
    .res         (res)
  );

  // Result queue decouples the sequencer from the consumer.
  i2cms_fifo #(
    .WIDTH ($bits(i2cms_pkg::i2cms_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fire),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign scl_out     = res_head.scl_out;
  assign sda_out     = res_head.sda_out;
  assign sda_oe      = res_head.sda_oe;
  assign busy_res    = res_head.busy_res;
  assign done_res    = res_head.done_res;
  assign rx_byte     = res_head.rx_byte;
  assign ack_missing = res_head.ack_missing;
  assign line_status = res_head.line_status;

`ifndef SYNTHESIS
  // A completing tick never leaves the sequencer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(res.done_res && res.busy_res))
    else $error("done and busy both set on one tick");

  // Reset leaves the result queue empty and the request queue not full.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // Line status of a result always tracks the request it came from.
  a_status_path: assert property (@(posedge clk) disable iff (rst)
    fire |-> (res.line_status == item.line_status))
    else $error("line status lost between request and result");
`endif

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the I2C master bit sequencer: directed table plus random transfers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length guard: about 2.5k ticks worst case, with the limit set several times over that run.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned MAX_REPORTS = 40;

  // Random phases: bus timing and ack timeout per phase.
  localparam int unsigned N_PHASES = 4;
  localparam logic [15:0] PHASE_SET [N_PHASES] = '{16'd1, 16'd2, 16'd5, 16'd1};
  localparam logic [7:0]  TMO_SET   [N_PHASES] = '{8'd1, 8'd7, 8'd255, 8'd20};
  localparam int unsigned TICKS_PER_PHASE = 200;

  // Directed stimulus rows.
  typedef enum logic [1:0] {
    ROW_TICK,       // one request, nothing more
    ROW_CMD,        // one request, then idle requests until the command is over
    ROW_SET_PHASE,  // write phase_ticks with arg
    ROW_SET_TMO     // write ack_timeout with arg
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  valid;
    i2cms_pkg::i2cms_cmd_t cmd;
    logic [15:0]           arg;
    logic                  sda;
    logic                  scl;
    logic                  typed;  // want holds the result of this request
    i2cms_pkg::i2cms_res_t want;
  } row_t;

  localparam int unsigned DIR_ROWS = 26;
  localparam row_t DIR_TAB [DIR_ROWS] = '{
    // out of reset: idle, lines high and driven, status code from the inputs
    '{ROW_TICK, 1'b0, i2cms_pkg::CMD_START, 16'h0000, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 2'd3}},
    '{ROW_TICK, 1'b0, i2cms_pkg::CMD_STATUS, 16'h00ff, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 2'd2}},
    '{ROW_TICK, 1'b0, i2cms_pkg::CMD_NACK, 16'h00aa, 1'b1, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 2'd1}},
    '{ROW_TICK, 1'b0, i2cms_pkg::CMD_READ, 16'h0055, 1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 2'd0}},
    // status releases SDA at once and stays busy for one phase at the reset phase length
    '{ROW_TICK, 1'b1, i2cms_pkg::CMD_STATUS, 16'h0000, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 2'd2}},
    '{ROW_SET_PHASE, 1'b0, i2cms_pkg::CMD_START, 16'd1, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_START, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WRITE, 16'h00ff, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WAIT, 16'h0000, 1'b0, 1'b1, 1'b0, '0},   // ack seen
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WRITE, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WAIT, 16'h0000, 1'b1, 1'b1, 1'b0, '0},   // timeout at reset limit
    '{ROW_SET_TMO, 1'b0, i2cms_pkg::CMD_START, 16'd1, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_START, 16'h0000, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WRITE, 16'h005a, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_WAIT, 16'h0000, 1'b1, 1'b0, 1'b0, '0},   // timeout at limit 1
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_START, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_READ, 16'h0000, 1'b1, 1'b1, 1'b0, '0},   // all ones
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_ACK, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_READ, 16'h00ff, 1'b0, 1'b0, 1'b0, '0},   // all zeros
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_NACK, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_STOP, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_SET_TMO, 1'b0, i2cms_pkg::CMD_START, 16'd255, 1'b0, 1'b0, 1'b0, '0},
    // zero phase length behaves as a phase length of one
    '{ROW_SET_PHASE, 1'b0, i2cms_pkg::CMD_START, 16'd0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_SET_PHASE, 1'b0, i2cms_pkg::CMD_START, 16'd40, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CMD, 1'b1, i2cms_pkg::CMD_STATUS, 16'h0000, 1'b1, 1'b0, 1'b0, '0}
  };

  // DUT ports; the inputs are all known from time zero
  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd_valid = 1'b0;
  logic [2:0]  command = '0;
  logic [7:0]  tx_byte = '0;
  logic        sda_in = 1'b0;
  logic        scl_in = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        sda_oe;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic        ack_missing;
  logic [1:0]  line_status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  i2c_master_bit_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .cmd_valid(cmd_valid), .command(command), .tx_byte(tx_byte),
    .sda_in(sda_in), .scl_in(scl_in),
    .empty(empty), .pop(pop),
    .scl_out(scl_out), .sda_out(sda_out), .sda_oe(sda_oe),
    .busy_res(busy_res), .done_res(done_res), .rx_byte(rx_byte),
    .ack_missing(ack_missing), .line_status(line_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Bus sequencer predictor. State starts at its reset values.
  // ---------------------------------------------------------------------------
  logic [3:0]            st_step   = i2cms_pkg::STEP_IDLE;
  logic [15:0]           st_phase  = '0;
  logic [3:0]            st_bit    = '0;
  logic [7:0]            st_shift  = '0;
  i2cms_pkg::i2cms_cmd_t st_cmd    = i2cms_pkg::CMD_START;
  logic [7:0]            st_wait   = '0;     // high SDA samples seen while polling for ack
  logic                  lvl_scl   = 1'b1;
  logic                  lvl_sda   = 1'b1;
  logic                  drv_sda   = 1'b1;
  logic                  nack_flag = 1'b0;
  logic [7:0]            rx_hold   = '0;
  logic [15:0]           cfg_phase = i2cms_pkg::PHASE_TICKS_RST;
  logic [7:0]            cfg_tmo   = i2cms_pkg::ACK_TIMEOUT_RST;

  // Stop condition, phase k of 3: pull both low, raise SCL, then raise SDA.
  function automatic void stop_levels(input logic [3:0] k);
    if (k == 4'd1) begin
      drv_sda = 1'b1;
      lvl_scl = 1'b0;
      lvl_sda = 1'b0;
    end else if (k == 4'd2) begin
      lvl_scl = 1'b1;
    end else begin
      lvl_sda = 1'b1;
    end
  endfunction

  // Line levels set when the sequencer enters st_step of st_cmd.
  function automatic void enter_levels(input logic s);
    case (st_cmd)
      i2cms_pkg::CMD_START: begin
        if (st_step == 4'd1) begin
          drv_sda = 1'b1;
          lvl_sda = 1'b1;
        end else if (st_step == 4'd2) lvl_scl = 1'b1;
        else if (st_step == 4'd3) lvl_sda = 1'b0;
        else lvl_scl = 1'b0;
      end
      i2cms_pkg::CMD_STOP: stop_levels(st_step);
      i2cms_pkg::CMD_WAIT: begin
        if (st_step == 4'd1) begin
          drv_sda = 1'b0;
          lvl_sda = 1'b1;
        end else if (st_step == 4'd2) lvl_scl = 1'b1;
        else if (st_step >= 4'd4) stop_levels(st_step - 4'd3);
      end
      i2cms_pkg::CMD_WRITE: begin
        if (st_step == 4'd1) begin
          drv_sda  = 1'b1;
          lvl_scl  = 1'b0;
          lvl_sda  = st_shift[7];
          st_shift = {st_shift[6:0], 1'b0};
        end else if (st_step == 4'd2) lvl_scl = 1'b1;
        else lvl_scl = 1'b0;
      end
      i2cms_pkg::CMD_READ: begin
        if (st_step == 4'd1) begin
          drv_sda = 1'b0;
          lvl_scl = 1'b0;
        end else begin
          // sample on the first tick of SCL high
          lvl_scl  = 1'b1;
          st_shift = {st_shift[6:0], s};
        end
      end
      i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
        if (st_step == 4'd1) begin
          lvl_scl = 1'b0;
          drv_sda = 1'b1;
          lvl_sda = (st_cmd == i2cms_pkg::CMD_NACK);
        end else lvl_scl = 1'b1;
      end
      default: begin
        drv_sda = 1'b0;
        lvl_scl = 1'b1;
      end
    endcase
  endfunction

  // One tick of the sequencer: consumes one request, returns the result it causes.
  function automatic i2cms_pkg::i2cms_res_t bus_tick(input logic v,
                                                     input i2cms_pkg::i2cms_cmd_t c,
                                                     input logic [7:0] b, input logic s,
                                                     input logic l);
    i2cms_pkg::i2cms_res_t r;
    logic fin;
    fin = 1'b0;
    if (st_step == i2cms_pkg::STEP_IDLE) begin
      if (v) begin
        st_cmd   = c;
        st_step  = 4'd1;
        st_bit   = '0;
        st_wait  = '0;
        st_phase = 16'd1;
        if (c == i2cms_pkg::CMD_WRITE) st_shift = b;
        else if (c == i2cms_pkg::CMD_READ) st_shift = '0;
        if (c == i2cms_pkg::CMD_WAIT) nack_flag = 1'b0;
        enter_levels(s);
      end
    end else if (st_cmd == i2cms_pkg::CMD_WAIT && st_step == i2cms_pkg::STEP_POLL) begin
      // ack polling ignores the phase counter
      if (!s) begin
        lvl_scl   = 1'b0;
        nack_flag = 1'b0;
        fin       = 1'b1;
      end else if (st_wait >= cfg_tmo) begin
        nack_flag = 1'b1;
        st_step   = 4'd4;
        enter_levels(s);
        st_phase  = 16'd1;
      end else begin
        st_wait = st_wait + 8'd1;
      end
    end else if (st_phase >= cfg_phase) begin
      // phase over: next step, next bit, or done
      case (st_cmd)
        i2cms_pkg::CMD_START: if (st_step < 4'd4) st_step = st_step + 4'd1; else fin = 1'b1;
        i2cms_pkg::CMD_STOP:  if (st_step < 4'd3) st_step = st_step + 4'd1; else fin = 1'b1;
        i2cms_pkg::CMD_WAIT:  if (st_step < 4'd6) st_step = st_step + 4'd1; else fin = 1'b1;
        i2cms_pkg::CMD_WRITE: begin
          if (st_step < 4'd3) st_step = st_step + 4'd1;
          else if (st_bit < 4'd7) begin
            st_bit  = st_bit + 4'd1;
            st_step = 4'd1;
          end else fin = 1'b1;
        end
        i2cms_pkg::CMD_READ: begin
          if (st_step < 4'd2) st_step = st_step + 4'd1;
          else if (st_bit < 4'd7) begin
            st_bit  = st_bit + 4'd1;
            st_step = 4'd1;
          end else begin
            rx_hold = st_shift;
            fin     = 1'b1;
          end
        end
        i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
          if (st_step < 4'd2) st_step = st_step + 4'd1;
          else begin
            lvl_scl = 1'b0;
            fin     = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
      if (!fin) begin
        enter_levels(s);
        st_phase = 16'd1;
      end
    end else begin
      st_phase = st_phase + 16'd1;
    end
    if (fin) st_step = i2cms_pkg::STEP_IDLE;

    r.scl_out     = lvl_scl;
    r.sda_out     = lvl_sda;
    r.sda_oe      = drv_sda;
    r.busy_res    = (st_step != i2cms_pkg::STEP_IDLE);
    r.done_res    = fin;
    r.rx_byte     = rx_hold;
    r.ack_missing = nack_flag;
    r.line_status = 2'd3 - {s, l};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  i2cms_pkg::i2cms_res_t pending_res [$];   // predicted results, oldest first
  int unsigned errors     = 0;
  int unsigned ticks_sent = 0;
  int unsigned res_seen   = 0;
  int unsigned cmds_done  = 0;
  int unsigned ack_tmos   = 0;
  int unsigned cmd_seen [8] = '{default: 0};
  int unsigned cycle_n    = 0;
  logic        gaps_on    = 1'b1;  // random idle bursts on both sides
  int          sda_pin    = -1;    // >= 0: SDA held at this level for the whole command
  int          hold_hi    = -1;    // poll samples with SDA high before ack; < 0: random

  // SDA for the next request, picked from where the sequencer stands now.
  function automatic logic next_sda();
    if (sda_pin >= 0) return sda_pin[0];
    if (st_cmd == i2cms_pkg::CMD_WAIT && st_step == i2cms_pkg::STEP_POLL && hold_hi >= 0) begin
      if (hold_hi > 0) begin
        hold_hi = hold_hi - 1;
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: pop stalls in random bursts, each accepted result checked
  // ---------------------------------------------------------------------------
  initial begin
    int stall = 0;
    forever begin
      @(negedge clk);
      if (gaps_on && stall == 0 && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 12);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    i2cms_pkg::i2cms_res_t got;
    i2cms_pkg::i2cms_res_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {scl_out, sda_out, sda_oe, busy_res, done_res, rx_byte, ack_missing, line_status};
        res_seen++;
        if (pending_res.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: no result expected, actual %h", $time, got);
        end else begin
          want = pending_res.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          check_field("sda_oe", 8'(want.sda_oe), 8'(got.sda_oe));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
          check_field("line_status", 8'(want.line_status), 8'(got.line_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task is entered just after a falling edge.
  // ---------------------------------------------------------------------------

  // Push one request; typed rows supply their own result, others use the predictor.
  task automatic send_tick(input logic v, input i2cms_pkg::i2cms_cmd_t c, input logic [7:0] b,
                           input logic s, input logic l, input logic typed,
                           input i2cms_pkg::i2cms_res_t want);
    i2cms_pkg::i2cms_res_t r;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push      <= 1'b1;
    cmd_valid <= v;
    command   <= c;
    tx_byte   <= b;
    sda_in    <= s;
    scl_in    <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    if (st_step == i2cms_pkg::STEP_IDLE && v) cmd_seen[c]++;
    r = bus_tick(v, c, b, s, l);
    if (r.done_res) cmds_done++;
    if (r.done_res && st_cmd == i2cms_pkg::CMD_WAIT && r.ack_missing) ack_tmos++;
    pending_res.push_back(typed ? want : r);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Idle requests until the running command is over; now and then a command
  // is presented anyway, which the busy sequencer must ignore.
  task automatic finish_cmd();
    while (st_step != i2cms_pkg::STEP_IDLE)
      send_tick(($urandom_range(0, 5) == 0), i2cms_pkg::i2cms_cmd_t'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), next_sda(), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic run_cmd(input i2cms_pkg::i2cms_cmd_t c, input logic [7:0] b);
    if (c == i2cms_pkg::CMD_WAIT) begin
      case ($urandom_range(0, 6))
        0:       hold_hi = 300;                    // slave never acks
        1:       hold_hi = -1;                     // SDA noise while polling
        default: hold_hi = $urandom_range(0, 4);   // late ack
      endcase
    end
    repeat ($urandom_range(0, 1))
      send_tick(1'b0, i2cms_pkg::i2cms_cmd_t'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), next_sda(), 1'($urandom_range(0, 1)), 1'b0, '0);
    send_tick(1'b1, c, b, next_sda(), 1'($urandom_range(0, 1)), 1'b0, '0);
    finish_cmd();
  endtask

  // Register write with the sequencer idle and every result drained.
  task automatic write_reg(input logic idx, input logic [15:0] val);
    finish_cmd();
    push <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);   // settle with nothing in flight
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == i2cms_pkg::REG_PHASE_TICKS) cfg_phase = val;
    else cfg_tmo = val[7:0];
  endtask

  // Mostly well-formed transfers with random content; the rest are lone
  // commands in any order and transfers cut short without a stop.
  task automatic random_transfer();
    logic [7:0] addr;
    int n;
    addr = 8'($urandom_range(0, 255));
    n = $urandom_range(1, 3);
    if ($urandom_range(0, 4) == 0) begin
      run_cmd(i2cms_pkg::i2cms_cmd_t'($urandom_range(0, 7)), addr);
      return;
    end
    run_cmd(i2cms_pkg::CMD_START, addr);
    run_cmd(i2cms_pkg::CMD_WRITE, addr);
    run_cmd(i2cms_pkg::CMD_WAIT, addr);
    // a timed-out wait has already put a stop on the bus
    for (int k = 0; k < n && !nack_flag; k++) begin
      if (addr[0]) begin
        run_cmd(i2cms_pkg::CMD_READ, addr);
        run_cmd((k == n - 1) ? i2cms_pkg::CMD_NACK : i2cms_pkg::CMD_ACK, addr);
      end else begin
        run_cmd(i2cms_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
        run_cmd(i2cms_pkg::CMD_WAIT, addr);
      end
    end
    if (!nack_flag && $urandom_range(0, 7) != 0) run_cmd(i2cms_pkg::CMD_STOP, addr);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    row_t row;
    int unsigned start_ticks;
    int unsigned drain_n;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      case (row.kind)
        ROW_SET_PHASE: write_reg(i2cms_pkg::REG_PHASE_TICKS, row.arg);
        ROW_SET_TMO:   write_reg(i2cms_pkg::REG_ACK_TIMEOUT, {8'd0, row.arg[7:0]});
        default: begin
          sda_pin = int'(row.sda);
          send_tick(row.valid, row.cmd, row.arg[7:0], row.sda, row.scl, row.typed, row.want);
          if (row.kind == ROW_CMD) finish_cmd();
        end
      endcase
    end
    sda_pin = -1;

    // random phases, one bus timing each; the last one runs without idling
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(i2cms_pkg::REG_PHASE_TICKS, PHASE_SET[p]);
      write_reg(i2cms_pkg::REG_ACK_TIMEOUT, {8'd0, TMO_SET[p]});
      if (p == N_PHASES - 1) gaps_on = 1'b0;
      start_ticks = ticks_sent;
      while (ticks_sent - start_ticks < TICKS_PER_PHASE) begin
        random_transfer();
        // sender holds off until the result queue runs dry
        if ($urandom_range(0, 14) == 0) begin
          push <= 1'b0;
          while (pending_res.size() != 0) @(negedge clk);
        end
      end
    end

    // wind down: wait out the pipeline, then look for stragglers
    push <= 1'b0;
    drain_n = 0;
    while (pending_res.size() != 0 && drain_n < 5000) begin
      @(negedge clk);
      drain_n++;
    end
    repeat (8) @(negedge clk);
    if (pending_res.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_res.size());
    end

    $display("summary: %0d requests, %0d results checked, %0d commands done, %0d ack timeouts",
             ticks_sent, res_seen, cmds_done, ack_tmos);
    $display("summary: start %0d stop %0d write %0d read %0d wait %0d ack %0d nack %0d status %0d",
             cmd_seen[i2cms_pkg::CMD_START], cmd_seen[i2cms_pkg::CMD_STOP],
             cmd_seen[i2cms_pkg::CMD_WRITE], cmd_seen[i2cms_pkg::CMD_READ],
             cmd_seen[i2cms_pkg::CMD_WAIT], cmd_seen[i2cms_pkg::CMD_ACK],
             cmd_seen[i2cms_pkg::CMD_NACK], cmd_seen[i2cms_pkg::CMD_STATUS]);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
